>>> rtl/core/hee_pkg.sv
// Package for the HTML entity escape encoder.
// Holds character codes, class codes, stage structs and the lookup functions.
// No dependencies.
package hee_pkg;

  // Character codes
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_L    = 8'h6C;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_P    = 8'h70;
  localparam logic [7:0] CH_Q    = 8'h71;
  localparam logic [7:0] CH_U    = 8'h75;
  localparam logic [7:0] CH_O    = 8'h6F;

  // Longest escape run in bytes
  localparam int RunMax = 6;
  localparam int LenW   = $clog2(RunMax + 1);

  // Byte classes
  localparam logic [2:0] CLS_PASS = 3'd0;
  localparam logic [2:0] CLS_LT   = 3'd1;
  localparam logic [2:0] CLS_GT   = 3'd2;
  localparam logic [2:0] CLS_AMP  = 3'd3;
  localparam logic [2:0] CLS_QUOT = 3'd4;
  localparam logic [2:0] CLS_NUM  = 3'd5;

  // Classified byte with its decimal digits
  typedef struct packed {
    logic [2:0] cls;
    logic [7:0] raw;
    logic [1:0] ndig;
    logic [1:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } cls_t;

  // Assembled output run, first byte in slot 0
  typedef struct packed {
    logic [RunMax-1:0][7:0] bytes;
    logic [LenW-1:0]        len;
  } run_t;

  // Whitelisted bytes pass through as they are
  function automatic logic is_passed(input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    case (b) inside
      [8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]: hit = 1'b1;
      8'h21, 8'h40, 8'h23, 8'h24, 8'h5E, 8'h2A, 8'h28, 8'h29,
      8'h60, 8'h7E, 8'h2D, 8'h5F, 8'h3D, 8'h2B, 8'h7B, 8'h7D,
      8'h5B, 8'h5D, 8'h20, 8'h09, 8'h0D, 8'h0A, 8'h5C, 8'h7C,
      8'h3B, 8'h3A, 8'h27, 8'h2C, 8'h2E, 8'h2F, 8'h3F: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Map a byte to its class
  function automatic logic [2:0] classify(input logic [7:0] b);
    logic [2:0] c;
    c = CLS_NUM;
    unique case (b)
      CH_LT:   c = CLS_LT;
      CH_GT:   c = CLS_GT;
      CH_AMP:  c = CLS_AMP;
      CH_QUOT: c = CLS_QUOT;
      default: c = is_passed(b) ? CLS_PASS : CLS_NUM;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/hee_classify.sv
// First stage: classify the byte and split it into decimal digits.
// Depends on hee_pkg.
module hee_classify
  import hee_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic       drain,
  input  logic [7:0] text_byte,
  output logic       valid,
  output cls_t       cls
);

  logic [1:0]  hund;
  logic [6:0]  rem100;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  ones_w;
  cls_t        cls_next;

  // Hundreds by compare, tens by reciprocal of ten, ones by subtraction
  always_comb begin
    if (text_byte >= 8'd200) begin
      hund   = 2'd2;
      rem100 = 7'(text_byte - 8'd200);
    end else if (text_byte >= 8'd100) begin
      hund   = 2'd1;
      rem100 = 7'(text_byte - 8'd100);
    end else begin
      hund   = 2'd0;
      rem100 = text_byte[6:0];
    end
    prod   = {8'd0, rem100} * 15'd205;
    tens   = prod[14:11];
    ones_w = rem100 - ({3'd0, tens} * 7'd10);

    cls_next.cls  = classify(text_byte);
    cls_next.raw  = text_byte;
    cls_next.hund = hund;
    cls_next.tens = tens;
    cls_next.ones = ones_w[3:0];
    if (text_byte >= 8'd100)
      cls_next.ndig = 2'd3;
    else if (text_byte >= 8'd10)
      cls_next.ndig = 2'd2;
    else
      cls_next.ndig = 2'd1;
  end

  // Hold the stage valid until the next stage takes it
  always_ff @(posedge clk) begin
    if (rst)
      valid <= 1'b0;
    else if (load)
      valid <= 1'b1;
    else if (drain)
      valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load)
      cls <= cls_next;
  end

endmodule

>>> rtl/core/hee_build.sv
// Second stage: assemble the escape run for one classified byte.
// Depends on hee_pkg.
module hee_build
  import hee_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic drain,
  input  cls_t cls,
  output logic valid,
  output run_t run
);

  run_t       run_next;
  logic [7:0] d_hund;
  logic [7:0] d_tens;
  logic [7:0] d_ones;

  // Build the run by class
  always_comb begin
    d_hund = CH_ZERO + {6'd0, cls.hund};
    d_tens = CH_ZERO + {4'd0, cls.tens};
    d_ones = CH_ZERO + {4'd0, cls.ones};
    run_next.bytes = '0;
    run_next.len   = LenW'(1);
    unique case (cls.cls)
      CLS_PASS: begin
        run_next.bytes[0] = cls.raw;
        run_next.len      = LenW'(1);
      end
      CLS_LT: begin
        run_next.bytes[0] = CH_AMP;
        run_next.bytes[1] = CH_L;
        run_next.bytes[2] = CH_T;
        run_next.bytes[3] = CH_SEMI;
        run_next.len      = LenW'(4);
      end
      CLS_GT: begin
        run_next.bytes[0] = CH_AMP;
        run_next.bytes[1] = CH_G;
        run_next.bytes[2] = CH_T;
        run_next.bytes[3] = CH_SEMI;
        run_next.len      = LenW'(4);
      end
      CLS_AMP: begin
        run_next.bytes[0] = CH_AMP;
        run_next.bytes[1] = CH_A;
        run_next.bytes[2] = CH_M;
        run_next.bytes[3] = CH_P;
        run_next.bytes[4] = CH_SEMI;
        run_next.len      = LenW'(5);
      end
      CLS_QUOT: begin
        run_next.bytes[0] = CH_AMP;
        run_next.bytes[1] = CH_Q;
        run_next.bytes[2] = CH_U;
        run_next.bytes[3] = CH_O;
        run_next.bytes[4] = CH_T;
        run_next.bytes[5] = CH_SEMI;
        run_next.len      = LenW'(6);
      end
      default: begin
        run_next.bytes[0] = CH_AMP;
        run_next.bytes[1] = CH_HASH;
        case (cls.ndig)
          2'd3: begin
            run_next.bytes[2] = d_hund;
            run_next.bytes[3] = d_tens;
            run_next.bytes[4] = d_ones;
            run_next.bytes[5] = CH_SEMI;
            run_next.len      = LenW'(6);
          end
          2'd2: begin
            run_next.bytes[2] = d_tens;
            run_next.bytes[3] = d_ones;
            run_next.bytes[4] = CH_SEMI;
            run_next.len      = LenW'(5);
          end
          default: begin
            run_next.bytes[2] = d_ones;
            run_next.bytes[3] = CH_SEMI;
            run_next.len      = LenW'(4);
          end
        endcase
      end
    endcase
  end

  // Hold the stage valid until the emitter takes it
  always_ff @(posedge clk) begin
    if (rst)
      valid <= 1'b0;
    else if (load)
      valid <= 1'b1;
    else if (drain)
      valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load)
      run <= run_next;
  end

endmodule

>>> rtl/core/hee_emit.sv
// Third stage: shift the assembled run out one byte per cycle.
// Depends on hee_pkg.
module hee_emit
  import hee_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  run_t       run,
  output logic       ready,
  output logic       strobe,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  logic [RunMax-1:0][7:0] bytes;
  logic [LenW-1:0]        rem;

  // Take a new run when empty or on the last byte of the current one
  assign ready       = !strobe || (rem == LenW'(1));
  assign out_byte    = bytes[0];
  assign last_of_run = (rem == LenW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      rem    <= '0;
    end else if (load) begin
      strobe <= 1'b1;
      rem    <= run.len;
    end else if (strobe) begin
      strobe <= (rem != LenW'(1));
      rem    <= rem - LenW'(1);
    end
  end

  // Advance the byte shifter
  always_ff @(posedge clk) begin
    if (load)
      bytes <= run.bytes;
    else if (strobe)
      bytes <= {8'd0, bytes[RunMax-1:1]};
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (rem != '0) && (rem <= LenW'(RunMax)))
    else $error("run count out of range while emitting");

  a_load_len: assert property (@(posedge clk) disable iff (rst)
    load |=> strobe && (rem == $past(run.len)))
    else $error("loaded run length lost");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_of_run && !load) |=> strobe && (rem == $past(rem) - LenW'(1)))
    else $error("run count did not step down");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    load |-> ready)
    else $error("run loaded over an unfinished run");

endmodule

>>> rtl/core/html_entity_escape_encoder_top.sv
// HTML entity escape encoder: one text byte in, a run of 1 to 6 bytes out.
// First output byte strobed after the start byte passes the classify, build and emit registers.
// Throughput: one input per cycle for pass-through bytes; an escape run occupies
// the output shifter until its last byte is strobed, so input is taken at one per run.
// Synchronous active-high reset empties all three stages; the receiver cannot stall.
module html_entity_escape_encoder_top
  import hee_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] text_byte,
  output logic       busy,
  output logic       strobe,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  logic s1_valid;
  logic s2_valid;
  logic em_ready;
  logic s1_load;
  logic s2_load;
  logic em_load;
  cls_t s1_cls;
  run_t s2_run;

  // Stage handshakes: each stage moves on when the one after it has room
  assign em_load = s2_valid && em_ready;
  assign s2_load = s1_valid && (!s2_valid || em_ready);
  assign busy    = s1_valid && s2_valid && !em_ready;
  assign s1_load = start && !busy;

  hee_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_load),
    .drain     (s2_load),
    .text_byte (text_byte),
    .valid     (s1_valid),
    .cls       (s1_cls)
  );

  hee_build u_build (
    .clk   (clk),
    .rst   (rst),
    .load  (s2_load),
    .drain (em_load),
    .cls   (s1_cls),
    .valid (s2_valid),
    .run   (s2_run)
  );

  hee_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (em_load),
    .run         (s2_run),
    .ready       (em_ready),
    .strobe      (strobe),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  a_hold_s2: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !em_ready) |=> s2_valid && $stable(s2_run))
    else $error("stalled run dropped or changed");

  a_hold_s1: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_load) |=> s1_valid && $stable(s1_cls))
    else $error("stalled byte dropped or changed");

  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> s1_valid && s2_valid && strobe && !last_of_run)
    else $error("busy raised with room in the pipe");

endmodule
